// ===== rtl/xtea_pkg.sv =====
// ----------------------------------------------------------------------------
// xtea_pkg
// Shared types, constants and schedule functions of the XTEA cipher pipeline.
// ----------------------------------------------------------------------------
package xtea_pkg;

   localparam int unsigned WORD_W    = 32;
   localparam int unsigned KEY_WORDS = 4;
   localparam int unsigned KEY_IDX_W = $clog2(KEY_WORDS);
   localparam int unsigned ROUNDS    = 32;
   localparam int unsigned STAGES    = 2 * ROUNDS;

   localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

   localparam logic ACT_ENCRYPT = 1'b0;
   localparam logic ACT_DECRYPT = 1'b1;

   typedef struct packed {
      logic              action;
      logic [WORD_W-1:0] word_first;
      logic [WORD_W-1:0] word_second;
   } xtea_req_type;

   typedef struct packed {
      logic [WORD_W-1:0] out_first;
      logic [WORD_W-1:0] out_second;
   } xtea_rsp_type;

   // block state carried between half-round stages
   typedef struct packed {
      logic              action;
      logic [WORD_W-1:0] v0;
      logic [WORD_W-1:0] v1;
   } xtea_stg_type;

   // per-stage constants: round sums for both directions and stage parity
   typedef struct packed {
      logic [WORD_W-1:0] sum_enc;
      logic [WORD_W-1:0] sum_dec;
      logic              odd;
   } xtea_sched_type;

   typedef logic [KEY_WORDS-1:0][WORD_W-1:0] xtea_key_type;

   function automatic logic [WORD_W-1:0] delta_times(int unsigned n);
      logic [WORD_W-1:0] nv;
      nv = WORD_W'(n);
      return WORD_W'(nv * DELTA);
   endfunction

   // half-round k: encrypt uses ((k+1)/2)*delta, decrypt (ROUNDS-(k+1)/2)*delta
   function automatic xtea_sched_type stage_sched(int unsigned k);
      xtea_sched_type s;
      s.sum_enc = delta_times((k + 1) / 2);
      s.sum_dec = delta_times(ROUNDS - (k + 1) / 2);
      s.odd     = 1'(k % 2);
      return s;
   endfunction

endpackage

// ===== rtl/xtea_stage.sv =====
// ----------------------------------------------------------------------------
// xtea_stage
// One registered XTEA half-round; direction and key select follow the item.
// ----------------------------------------------------------------------------
module xtea_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  xtea_pkg::xtea_stg_type  in_data,
   input  xtea_pkg::xtea_sched_type sched,
   input  xtea_pkg::xtea_key_type  key,
   output logic                    out_valid,
   output xtea_pkg::xtea_stg_type  out_data
);
   import xtea_pkg::*;

   logic                 upd_first;
   logic [WORD_W-1:0]    sum;
   logic [WORD_W-1:0]    src;
   logic [WORD_W-1:0]    dst;
   logic [KEY_IDX_W-1:0] kidx;
   logic [WORD_W-1:0]    mixed;
   logic [WORD_W-1:0]    tweak;
   logic [WORD_W-1:0]    fval;
   logic [WORD_W-1:0]    res;

   logic         valid_ff;
   xtea_stg_type data_ff;
   xtea_stg_type data_in;

   always_comb begin
      // encrypt even / decrypt odd stages update v0, using the low sum bits
      upd_first = ~(in_data.action ^ sched.odd);
      sum       = (in_data.action == ACT_DECRYPT) ? sched.sum_dec : sched.sum_enc;
      src       = upd_first ? in_data.v1 : in_data.v0;
      dst       = upd_first ? in_data.v0 : in_data.v1;
      kidx      = upd_first ? sum[KEY_IDX_W-1:0] : sum[11 +: KEY_IDX_W];
      mixed     = ((src << 4) ^ (src >> 5)) + src;
      tweak     = sum + key[kidx];
      fval      = mixed ^ tweak;
      res       = (in_data.action == ACT_DECRYPT) ? (dst - fval) : (dst + fval);

      data_in.action = in_data.action;
      data_in.v0     = upd_first ? res : in_data.v0;
      data_in.v1     = upd_first ? in_data.v1 : res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/xtea_block_cipher_top.sv =====
// ----------------------------------------------------------------------------
// xtea_block_cipher_top
// XTEA 64-bit block encrypt/decrypt engine, 128-bit key.
// ----------------------------------------------------------------------------
// Fully pipelined XTEA engine: one 64-bit block item is accepted per clock
// while the pipeline is not stalled, one registered stage per half-round
// (each stage is one mix add and key add in parallel, then an xor and a
// final add or subtract). When a result is stalled the whole pipeline
// holds, so req_stall follows rsp_valid && rsp_stall. The user must write
// key words via the csr port only while no item is in flight (not enforced).
module xtea_block_cipher_top (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  xtea_pkg::xtea_req_type                    req_data,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output xtea_pkg::xtea_rsp_type                    rsp_data,
   input  logic                                      csr_we,
   input  logic [xtea_pkg::KEY_IDX_W-1:0]            csr_index,
   input  logic [xtea_pkg::WORD_W-1:0]               csr_wdata
);
   import xtea_pkg::*;

   xtea_key_type key_ff;
   logic         adv;
   logic         stg_valid [STAGES+1];
   xtea_stg_type stg_data  [STAGES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_we) begin
         key_ff[csr_index] <= csr_wdata;
      end
   end

   assign adv       = ~(stg_valid[STAGES] & rsp_stall);
   assign req_stall = ~adv;

   assign stg_valid[0]       = req_valid;
   assign stg_data[0].action = req_data.action;
   assign stg_data[0].v0     = req_data.word_first;
   assign stg_data[0].v1     = req_data.word_second;

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      xtea_stage u_stage (
         .clock    (clock),
         .reset    (reset),
         .en       (adv),
         .in_valid (stg_valid[k]),
         .in_data  (stg_data[k]),
         .sched    (stage_sched(k)),
         .key      (key_ff),
         .out_valid(stg_valid[k+1]),
         .out_data (stg_data[k+1])
      );
   end

   assign rsp_valid           = stg_valid[STAGES];
   assign rsp_data.out_first  = stg_data[STAGES].v0;
   assign rsp_data.out_second = stg_data[STAGES].v1;

endmodule

// ===== rtl/xtea_chk.sv =====
// ----------------------------------------------------------------------------
// xtea_chk
// Port-level checks of the XTEA pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module xtea_chk (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input xtea_pkg::xtea_req_type               req_data,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input xtea_pkg::xtea_rsp_type               rsp_data,
   input logic                                 csr_we,
   input logic [xtea_pkg::KEY_IDX_W-1:0]       csr_index,
   input logic [xtea_pkg::WORD_W-1:0]          csr_wdata
);
   import xtea_pkg::*;

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // input only backs up when a result is held
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a stalled result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled result dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind xtea_block_cipher_top xtea_chk u_xtea_chk (.*);
